/* src/mvr_pkg.sv */
`default_nettype none

package mvr_pkg;

  // longest chat text, in characters
  localparam int unsigned MAX_CHAT_CHARS = 48;

  // message layout
  localparam int unsigned HDR_LEN     = 5;
  localparam int unsigned STORE_DEPTH = HDR_LEN + MAX_CHAT_CHARS;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int unsigned SIZE_HELLO    = 1;
  localparam int unsigned SIZE_WELCOME  = 5;
  localparam int unsigned SIZE_STATE    = 13;
  localparam int unsigned SIZE_PING     = 13;
  localparam int unsigned SIZE_CHAT_MIN = 6;

  // printable text range
  localparam logic [7:0] TEXT_LO = 8'h20;
  localparam logic [7:0] TEXT_HI = 8'h7e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_HELLO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_WELCOME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_STATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_PING    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_CHAT    = 3'd4;

  // configuration reset values
  localparam logic [7:0] RST_CODE_HELLO   = 8'd0;
  localparam logic [7:0] RST_CODE_WELCOME = 8'd1;
  localparam logic [7:0] RST_CODE_STATE   = 8'd2;
  localparam logic [7:0] RST_CODE_PING    = 8'd3;
  localparam logic [7:0] RST_CODE_CHAT    = 8'd4;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // input transfer
    logic issue;   // start a buffer read for the next outgoing byte
    logic load;    // load the output register from the read data
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic send_ok;     // message being accepted is valid and gives output
    logic issue_done;  // all outgoing bytes have been read
  } stat_t;

endpackage

`default_nettype wire

/* src/mvr_ram.sv */
`default_nettype none

module mvr_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/mvr_ctrl.sv */
`default_nettype none

module mvr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          msg_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mvr_pkg::cmd_t      cmd_o,
  input  wire mvr_pkg::stat_t stat_i
);

  typedef enum logic [1:0] {
    S_RECV = 2'b01,
    S_SEND = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, issue, load;

  // handshake and command decode
  always_comb begin
    in_ready_o = (state_q == S_RECV);
    accept     = in_valid_i && in_ready_o;
    load       = pend_q && (!out_valid_q || out_ready_i);
    issue      = (state_q == S_SEND) && !stat_i.issue_done && (!pend_q || load);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_RECV: begin
        if (accept && msg_last_i && stat_i.send_ok) begin
          state_d = S_SEND;
        end
      end
      S_SEND: begin
        if (stat_i.issue_done && (!pend_q || load)) begin
          state_d = S_RECV;
        end
      end
      default: state_d = S_RECV;
    endcase
  end

  // read pending flag and output valid
  always_comb begin
    pend_d = pend_q;
    if (issue) begin
      pend_d = 1'b1;
    end else if (load) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RECV;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cmd_o.accept = accept;
  assign cmd_o.issue  = issue;
  assign cmd_o.load   = load;

endmodule

`default_nettype wire

/* src/mvr_dp.sv */
`default_nettype none

module mvr_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mvr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [7:0]                      cfg_data_i,
  input  wire logic [7:0]                      msg_byte_i,
  input  wire logic                            msg_last_i,
  input  wire logic [31:0]                     sender_peer_i,
  input  wire mvr_pkg::cmd_t                   cmd_i,
  output mvr_pkg::stat_t                       stat_o,
  output logic [7:0]                           out_byte_o,
  output logic                                 to_all_o,
  output logic [31:0]                          dest_peer_o,
  output logic                                 out_last_o
);

  localparam int unsigned AW = mvr_pkg::ADDR_W;
  localparam int unsigned CW = mvr_pkg::CNT_W;

  typedef enum logic [1:0] {
    MODE_HELLO,
    MODE_PING,
    MODE_BCAST
  } mode_e;

  // configuration registers
  logic [7:0] code_hello_q, code_welcome_q, code_state_q, code_ping_q, code_chat_q;

  // receive side state
  logic [CW-1:0] count_q, count_d;
  logic          text_bad_q, text_bad_d;
  logic          too_long_q, too_long_d;
  logic [7:0]    kind_q;
  logic [31:0]   sender_q;

  // replay side state
  mode_e         mode_q;
  logic [CW-1:0] len_q;
  logic [CW-1:0] issue_idx_q;
  logic [AW-1:0] rd_idx_q;

  logic [7:0]    ram_rdata;
  logic          wr_ok;
  logic          too_long_now, text_bad_now;
  logic [CW-1:0] size_now;
  logic [7:0]    kind_now;
  logic [31:0]   sender_now;
  logic          is_hello, is_welcome, is_state, is_ping, is_chat;
  logic          chat_ok, send_ok;
  mode_e         mode_d;
  logic [CW-1:0] len_d;
  logic [7:0]    byte_sel;
  logic [7:0]    sender_byte;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_hello_q   <= mvr_pkg::RST_CODE_HELLO;
      code_welcome_q <= mvr_pkg::RST_CODE_WELCOME;
      code_state_q   <= mvr_pkg::RST_CODE_STATE;
      code_ping_q    <= mvr_pkg::RST_CODE_PING;
      code_chat_q    <= mvr_pkg::RST_CODE_CHAT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mvr_pkg::REG_CODE_HELLO:   code_hello_q   <= cfg_data_i;
        mvr_pkg::REG_CODE_WELCOME: code_welcome_q <= cfg_data_i;
        mvr_pkg::REG_CODE_STATE:   code_state_q   <= cfg_data_i;
        mvr_pkg::REG_CODE_PING:    code_ping_q    <= cfg_data_i;
        mvr_pkg::REG_CODE_CHAT:    code_chat_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // view of the message including the byte now being transferred
  always_comb begin
    wr_ok        = count_q < CW'(mvr_pkg::STORE_DEPTH);
    too_long_now = too_long_q || !wr_ok;
    text_bad_now = text_bad_q ||
                   (wr_ok && count_q >= CW'(mvr_pkg::HDR_LEN) &&
                    (msg_byte_i < mvr_pkg::TEXT_LO || msg_byte_i > mvr_pkg::TEXT_HI));
    size_now     = count_q + CW'(1);
    kind_now     = (count_q == '0) ? msg_byte_i : kind_q;
    sender_now   = (count_q == '0 && !too_long_q) ? sender_peer_i : sender_q;
  end

  // kind and length check, first matching code wins
  always_comb begin
    is_hello   = kind_now == code_hello_q;
    is_welcome = kind_now == code_welcome_q;
    is_state   = kind_now == code_state_q;
    is_ping    = kind_now == code_ping_q;
    is_chat    = kind_now == code_chat_q;
    chat_ok    = size_now >= CW'(mvr_pkg::SIZE_CHAT_MIN) &&
                 size_now <= CW'(mvr_pkg::STORE_DEPTH) && !text_bad_now;
    send_ok    = 1'b0;
    mode_d     = MODE_BCAST;
    len_d      = size_now;
    if (is_hello) begin
      send_ok = size_now == CW'(mvr_pkg::SIZE_HELLO);
      mode_d  = MODE_HELLO;
      len_d   = CW'(mvr_pkg::SIZE_WELCOME);
    end else if (is_welcome) begin
      send_ok = 1'b0;
    end else if (is_state) begin
      send_ok = size_now == CW'(mvr_pkg::SIZE_STATE);
    end else if (is_ping) begin
      send_ok = size_now == CW'(mvr_pkg::SIZE_PING);
      mode_d  = MODE_PING;
    end else if (is_chat) begin
      send_ok = chat_ok;
    end
    send_ok = send_ok && !too_long_now;
  end

  // receive counters, cleared at the last byte
  always_comb begin
    count_d    = count_q;
    text_bad_d = text_bad_q;
    too_long_d = too_long_q;
    if (cmd_i.accept) begin
      if (msg_last_i) begin
        count_d    = '0;
        text_bad_d = 1'b0;
        too_long_d = 1'b0;
      end else begin
        count_d    = wr_ok ? size_now : count_q;
        text_bad_d = text_bad_now;
        too_long_d = too_long_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      text_bad_q <= 1'b0;
      too_long_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      text_bad_q <= text_bad_d;
      too_long_q <= too_long_d;
    end
  end

  // kind byte, sender and per message replay setup
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q   <= kind_now;
      sender_q <= sender_now;
      if (msg_last_i) begin
        mode_q <= mode_d;
        len_q  <= len_d;
      end
    end
  end

  // replay read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_idx_q <= '0;
    end else if (cmd_i.accept && msg_last_i) begin
      issue_idx_q <= '0;
    end else if (cmd_i.issue) begin
      issue_idx_q <= issue_idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_idx_q <= issue_idx_q[AW-1:0];
    end
  end

  // message buffer
  mvr_ram #(
    .WIDTH (8),
    .DEPTH (mvr_pkg::STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && wr_ok),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (msg_byte_i),
    .re_i    (cmd_i.issue),
    .raddr_i (issue_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // outgoing byte selection, sender id little endian in bytes 1 to 4 of hello and broadcast replies
  always_comb begin
    sender_byte = 8'h00;
    case (rd_idx_q)
      AW'(1):  sender_byte = sender_q[7:0];
      AW'(2):  sender_byte = sender_q[15:8];
      AW'(3):  sender_byte = sender_q[23:16];
      AW'(4):  sender_byte = sender_q[31:24];
      default: sender_byte = 8'h00;
    endcase
    byte_sel = ram_rdata;
    if (mode_q == MODE_HELLO) begin
      byte_sel = (rd_idx_q == '0) ? code_welcome_q : sender_byte;
    end else if (mode_q == MODE_BCAST && rd_idx_q != '0 &&
                 rd_idx_q <= AW'(mvr_pkg::HDR_LEN - 1)) begin
      byte_sel = sender_byte;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_o  <= byte_sel;
      to_all_o    <= (mode_q == MODE_BCAST);
      dest_peer_o <= (mode_q == MODE_BCAST) ? 32'h0 : sender_q;
      out_last_o  <= (CW'(rd_idx_q) + CW'(1)) == len_q;
    end
  end

  assign stat_o.send_ok    = send_ok;
  assign stat_o.issue_done = issue_idx_q == len_q;

endmodule

`default_nettype wire

/* src/message_validate_relay.sv */
// Peer message checker and relay.
// Input channel: one message byte per transfer (msg_byte_i, msg_last_i,
// sender_peer_i), kind byte first; the sender id is taken from the first byte.
// Bytes are taken one per cycle into a 53-entry buffer while the block is
// receiving. At the last byte the kind and length are checked; a message
// that gives output blocks the input while it is replayed from the buffer.
// Output channel: one outgoing byte per transfer with to_all_o, dest_peer_o
// and out_last_o. After the last input byte, the first outgoing byte is read
// from the buffer and then loaded into the output register; after that one
// byte per cycle while the receiver is ready, limited by the single buffer
// read port. A relayed message is first received in full and then replayed
// from the buffer; a hello is answered with a five-byte welcome; dropped
// messages are only received.
// Configuration channel: cfg_index_i selects a kind code, always ready.
// Writes must be made only while no message is in flight; it is not enforced.
// Reset: kind codes return to their defaults and the buffer is empty; no
// clearing pass is needed. When the receiver stalls, the output register
// holds and replay pauses; input is taken again once the last byte of the
// reply is in the output register.
`default_nettype none

module message_validate_relay (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mvr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    msg_byte_i,
  input  wire logic                          msg_last_i,
  input  wire logic [31:0]                   sender_peer_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [7:0]                         out_byte_o,
  output logic                               to_all_o,
  output logic [31:0]                        dest_peer_o,
  output logic                               out_last_o
);

  mvr_pkg::cmd_t  cmd;
  mvr_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  // sequencing of receive and replay
  mvr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .msg_last_i  (msg_last_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // buffer, checks and output register
  mvr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .msg_byte_i    (msg_byte_i),
    .msg_last_i    (msg_last_i),
    .sender_peer_i (sender_peer_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_byte_o    (out_byte_o),
    .to_all_o      (to_all_o),
    .dest_peer_o   (dest_peer_o),
    .out_last_o    (out_last_o)
  );

  // no buffer read while bytes are being received
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !in_ready_o)
    else $error("buffer read during receive");

  // the output register is never overwritten while it holds a waiting byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten");

  // a message that passes the checks stops the input for its replay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && msg_last_i && stat.send_ok) |=> !in_ready_o)
    else $error("input still open after a valid message");

  // replay never starts with nothing to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && msg_last_i && stat.send_ok) |=> !stat.issue_done)
    else $error("empty replay");

endmodule

`default_nettype wire
